FILE: rtl/atd_pkg.sv
`timescale 1ns / 1ps
package atd_pkg;
   localparam int FracBits   = 16;
   localparam int ElemWidth  = 32;
   localparam int SqWidth    = 2 * ElemWidth + 2;
   localparam int RootWidth  = ElemWidth + 1;
   localparam int CordicW    = 34;
   localparam int CordicN    = 30;
   localparam int AngW       = 19;
   localparam logic signed [CordicW-1:0] PiQ30 = 34'sd3373259426;

   function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CordicW-1:0] r;
      unique case (idx)
         5'd0: r = 34'sd843314857;
         5'd1: r = 34'sd497837829;
         5'd2: r = 34'sd263043837;
         5'd3: r = 34'sd133525159;
         5'd4: r = 34'sd67021687;
         5'd5: r = 34'sd33543516;
         5'd6: r = 34'sd16775851;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194283;
         5'd9: r = 34'sd2097149;
         default: r = (idx < 5'd30) ? (34'sd1 <<< (5'd30 - idx)) : 34'sd0;
      endcase
      return r;
   endfunction

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SQ    = 9'b000000010,
      ST_ROOT  = 9'b000000100,
      ST_NORM  = 9'b000001000,
      ST_CSQ   = 9'b000010000,
      ST_CROOT = 9'b000100000,
      ST_CORD  = 9'b001000000,
      ST_DONE  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   typedef struct packed {
      logic       load_col;
      logic       start_t;
      logic       sq_step;
      logic       root_init;
      logic       root_step;
      logic       norm_init;
      logic       norm_step;
      logic       csq;
      logic       croot_init;
      logic       cord_init;
      logic       cord_step;
      logic       cord_store;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic col3;
      logic bottom_zero;
      logic root_done;
      logic col_done;
      logic norm_done;
      logic cord_done;
      logic gimbal;
   } stat_type;
endpackage

FILE: rtl/atd_if.sv
`timescale 1ns / 1ps
interface atd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  column_index;
   logic signed [31:0] elem0, elem1, elem2, elem3;
   modport source (output valid, column_index, elem0, elem1, elem2, elem3, input ready);
   modport sink (input valid, column_index, elem0, elem1, elem2, elem3, output ready);
endinterface

interface atd_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] trans_x, trans_y, trans_z;
   logic [30:0] scale_x, scale_y, scale_z;
   logic signed [18:0] angle_x, angle_y, angle_z;
   logic        decomposed_ok;
   modport source (output valid, trans_x, trans_y, trans_z, scale_x, scale_y, scale_z,
                   angle_x, angle_y, angle_z, decomposed_ok, input ready);
   modport sink (input valid, trans_x, trans_y, trans_z, scale_x, scale_y, scale_z,
                 angle_x, angle_y, angle_z, decomposed_ok, output ready);
endinterface

FILE: rtl/atd_datapath.sv
`timescale 1ns / 1ps
module atd_datapath (
   input  logic                clock,
   input  atd_pkg::cmd_type    cmd,
   output atd_pkg::stat_type   stat,
   input  logic [1:0]          in_col,
   input  logic signed [31:0]  in_e0,
   input  logic signed [31:0]  in_e1,
   input  logic signed [31:0]  in_e2,
   input  logic signed [31:0]  in_e3,
   output logic signed [31:0]  o_tx,
   output logic signed [31:0]  o_ty,
   output logic signed [31:0]  o_tz,
   output logic [30:0]         o_sx,
   output logic [30:0]         o_sy,
   output logic [30:0]         o_sz,
   output logic signed [18:0]  o_ax,
   output logic signed [18:0]  o_ay,
   output logic signed [18:0]  o_az
);
   localparam int EW = atd_pkg::ElemWidth;
   localparam int SW = atd_pkg::SqWidth;
   localparam int RW = atd_pkg::RootWidth;
   localparam int CW = atd_pkg::CordicW;
   localparam int FB = atd_pkg::FracBits;

   // basis columns, row-indexed per column
   logic signed [EW-1:0] basis_ff [9];
   logic signed [31:0]   trans_ff [3];
   logic [RW-1:0]        len_ff [3];
   logic signed [FB+1:0] n_ff [9];
   logic [SW-1:0]        acc_ff;
   logic [1:0]           sqi_ff;
   logic [RW-1:0]        root_ff;
   logic [SW-1:0]        rrem_ff;
   logic [6:0]           rbit_ff;
   logic [1:0]           kcol_ff;
   logic [1:0]           nrow_ff;
   logic [RW:0]          nrem_ff;
   logic [FB:0]          nq_ff;
   logic [5:0]           ncnt_ff;
   logic signed [CW-1:0] cx_ff, cy_ff, cz_ff;
   logic [4:0]           ci_ff;
   logic                 cdone_ff;
   logic signed [18:0]   ang_ff [3];

   logic signed [FB+1:0] one_s;
   logic signed [FB+1:0] s_v;
   logic [EW-1:0]        m_v;
   logic [RW-1:0]        root_t;
   logic [SW-1:0]        rsq;
   logic signed [EW-1:0] e_v;
   logic [RW:0]          nrem_sh;
   logic signed [FB+1:0] ay_s, ax_s, cyv, cxv;
   logic signed [CW-1:0] cordz;

   // magnitude of one stored element; column 3 reads as zero
   function automatic logic [EW-1:0] elem_mag(input logic [1:0] k, input logic [1:0] r);
      logic signed [EW-1:0] e;
      e = (k == 2'd3) ? '0 : basis_ff[k*3 + 32'(r)];
      return e[EW-1] ? EW'(-e) : EW'(e);
   endfunction

   function automatic logic [EW-1:0] mag_next(input logic [1:0] k, input logic [1:0] r);
      logic [1:0] nk, nr;
      nk = (r == 2'd2) ? k + 2'd1 : k;
      nr = (r == 2'd2) ? 2'd0 : r + 2'd1;
      return elem_mag(nk, nr);
   endfunction

   assign one_s = (FB+2)'(1) <<< FB;
   assign s_v   = -n_ff[2];
   assign stat.gimbal = (s_v == one_s) || (s_v == -one_s);
   assign stat.col3 = (in_col == 2'd3);
   assign stat.bottom_zero = (in_e3[EW-1:0] == '0);
   assign stat.root_done = (rbit_ff == '0);
   assign stat.col_done = (ncnt_ff == '0) && (nrow_ff == 2'd2);
   assign stat.norm_done = (ncnt_ff == '0) && (nrow_ff == 2'd2) && (kcol_ff == 2'd2);
   assign stat.cord_done = cdone_ff;

   // squared-sum operand, root trial square and shifted division remainder
   always_comb begin
      e_v = basis_ff[kcol_ff*3 + 32'(sqi_ff)];
      m_v = e_v[EW-1] ? EW'(-e_v) : EW'(e_v);
      root_t = root_ff | (RW'(1) << (rbit_ff - 7'd1));
      rsq = SW'(root_t) * SW'(root_t);
      nrem_sh = {nrem_ff[RW-1:0], 1'b0};
   end

   // cordic operands by selection
   always_comb begin
      unique case (cmd.sel)
         2'd0: begin cyv = s_v; cxv = (FB+2)'(signed'({1'b0, root_ff[FB:0]})); end
         2'd1: begin
            if (stat.gimbal) begin cyv = -n_ff[6]; cxv = n_ff[4]; end
            else begin cyv = n_ff[5]; cxv = n_ff[8]; end
         end
         default: begin cyv = n_ff[1]; cxv = n_ff[0]; end
      endcase
      ay_s = '0;
      ax_s = '0;
   end

   assign cordz = (cz_ff + (CW'(1) <<< (29 - FB))) >>> (30 - FB);

   always_ff @(posedge clock) begin
      if (cmd.load_col) begin
         if (in_col != 2'd3) begin
            basis_ff[in_col*3]     <= in_e0[EW-1:0];
            basis_ff[in_col*3 + 1] <= in_e1[EW-1:0];
            basis_ff[in_col*3 + 2] <= in_e2[EW-1:0];
         end else begin
            trans_ff[0] <= in_e0;
            trans_ff[1] <= in_e1;
            trans_ff[2] <= in_e2;
         end
      end
      if (cmd.start_t) begin
         kcol_ff <= 2'd0;
         acc_ff  <= '0;
         sqi_ff  <= 2'd0;
      end
      if (cmd.sq_step) begin
         acc_ff <= acc_ff + SW'(SW'(m_v) * SW'(m_v));
         sqi_ff <= sqi_ff + 2'd1;
      end
      if (cmd.root_init) begin
         root_ff <= '0;
         rrem_ff <= acc_ff;
         rbit_ff <= 7'(RW);
      end
      if (cmd.csq) begin
         rrem_ff <= SW'((64'(1) << (2*FB)) - 64'(64'(s_v) * 64'(s_v)));
         root_ff <= '0;
         rbit_ff <= 7'(RW);
      end
      if (cmd.root_step && rbit_ff != '0) begin
         if (rsq <= rrem_ff) root_ff <= root_t;
         rbit_ff <= rbit_ff - 7'd1;
      end
      if (cmd.norm_init) begin
         len_ff[kcol_ff] <= root_ff;
         nrow_ff <= 2'd0;
         nrem_ff <= (RW+1)'(elem_mag(kcol_ff, 2'd0));
         nq_ff   <= '0;
         ncnt_ff <= 6'(FB + 1);
         sqi_ff  <= 2'd0;
      end
      if (cmd.norm_step) begin
         if (ncnt_ff != '0) begin
            if (ncnt_ff == 6'(FB + 1)) begin
               if (len_ff[kcol_ff] != '0 && nrem_ff >= (RW+1)'(len_ff[kcol_ff])) begin
                  nrem_ff <= nrem_ff - (RW+1)'(len_ff[kcol_ff]);
                  nq_ff <= (FB+1)'(1);
               end
            end else if (nrem_sh >= (RW+1)'(len_ff[kcol_ff])) begin
               nrem_ff <= nrem_sh - (RW+1)'(len_ff[kcol_ff]);
               nq_ff <= {nq_ff[FB-1:0], 1'b1};
            end else begin
               nrem_ff <= nrem_sh;
               nq_ff <= {nq_ff[FB-1:0], 1'b0};
            end
            ncnt_ff <= ncnt_ff - 6'd1;
         end else begin
            n_ff[kcol_ff*3 + 32'(nrow_ff)] <= (len_ff[kcol_ff] == '0) ? '0 :
               (basis_ff[kcol_ff*3 + 32'(nrow_ff)][EW-1] ?
                -(FB+2)'(signed'({1'b0, nq_ff})) : (FB+2)'(signed'({1'b0, nq_ff})));
            nq_ff <= '0;
            ncnt_ff <= 6'(FB + 1);
            if (nrow_ff == 2'd2) begin
               nrow_ff <= 2'd0;
               kcol_ff <= kcol_ff + 2'd1;
               acc_ff  <= '0;
            end else begin
               nrow_ff <= nrow_ff + 2'd1;
            end
            // next element magnitude is loaded into remainder
            nrem_ff <= (RW+1)'(mag_next(kcol_ff, nrow_ff));
         end
      end
      if (cmd.cord_init) begin
         cdone_ff <= (cxv == '0) && (cyv == '0);
         ci_ff <= '0;
         if (cxv < 0) begin
            cx_ff <= -(CW'(cxv) <<< (30 - FB));
            cy_ff <= -(CW'(cyv) <<< (30 - FB));
            cz_ff <= (cyv >= 0) ? atd_pkg::PiQ30 : -atd_pkg::PiQ30;
         end else begin
            cx_ff <= CW'(cxv) <<< (30 - FB);
            cy_ff <= CW'(cyv) <<< (30 - FB);
            cz_ff <= '0;
         end
      end
      if (cmd.cord_step && !cdone_ff) begin
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + (cy_ff >>> ci_ff);
            cy_ff <= cy_ff - (cx_ff >>> ci_ff);
            cz_ff <= cz_ff + atd_pkg::atan_q30(ci_ff);
         end else if (cy_ff < 0) begin
            cx_ff <= cx_ff - (cy_ff >>> ci_ff);
            cy_ff <= cy_ff + (cx_ff >>> ci_ff);
            cz_ff <= cz_ff - atd_pkg::atan_q30(ci_ff);
         end
         ci_ff <= ci_ff + 5'd1;
         cdone_ff <= (cy_ff == '0) || (ci_ff == 5'(atd_pkg::CordicN - 1));
      end
      if (cmd.cord_store) begin
         ang_ff[cmd.sel] <= ((cmd.sel == 2'd2) && stat.gimbal) ? 19'sd0 : 19'(cordz);
      end
   end

   // outputs: translation, scale, then angles y, x and z
   assign o_tx = trans_ff[0];
   assign o_ty = trans_ff[1];
   assign o_tz = trans_ff[2];
   assign o_sx = (len_ff[0] > RW'(32'h7fffffff)) ? 31'h7fffffff : 31'(len_ff[0]);
   assign o_sy = (len_ff[1] > RW'(32'h7fffffff)) ? 31'h7fffffff : 31'(len_ff[1]);
   assign o_sz = (len_ff[2] > RW'(32'h7fffffff)) ? 31'h7fffffff : 31'(len_ff[2]);
   assign o_ay = ang_ff[0] + 19'(ay_s);
   assign o_ax = ang_ff[1] + 19'(ax_s);
   assign o_az = ang_ff[2];
endmodule

FILE: rtl/atd_control.sv
`timescale 1ns / 1ps
module atd_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               ok,
   output atd_pkg::cmd_type   cmd,
   input  atd_pkg::stat_type  stat
);
   atd_pkg::state_type state_ff, state_in;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       ok_ff, ok_in;
   logic       acc;

   assign req_ready = (state_ff == atd_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == atd_pkg::ST_OUT);
   assign ok = ok_ff;
   assign acc = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      cnt_in = cnt_ff;
      ok_in = ok_ff;
      cmd = '0;
      cmd.sel = sel_ff;
      unique case (state_ff)
         atd_pkg::ST_IDLE: begin
            if (acc) begin
               cmd.load_col = 1'b1;
               if (stat.col3) begin
                  ok_in = !stat.bottom_zero;
                  cmd.start_t = 1'b1;
                  cnt_in = 2'd0;
                  state_in = stat.bottom_zero ? atd_pkg::ST_OUT : atd_pkg::ST_SQ;
               end
            end
         end
         atd_pkg::ST_SQ: begin
            // three squares, then load the root once the sum is complete
            if (cnt_ff == 2'd3) begin
               cmd.root_init = 1'b1;
               cnt_in = 2'd0;
               state_in = atd_pkg::ST_ROOT;
            end else begin
               cmd.sq_step = 1'b1;
               cnt_in = cnt_ff + 2'd1;
            end
         end
         atd_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (stat.root_done) begin
               cmd.root_step = 1'b0;
               cmd.norm_init = 1'b1;
               state_in = atd_pkg::ST_NORM;
            end
         end
         atd_pkg::ST_NORM: begin
            // after each column, go back for the next column's length
            cmd.norm_step = 1'b1;
            if (stat.norm_done) state_in = atd_pkg::ST_CSQ;
            else if (stat.col_done) state_in = atd_pkg::ST_SQ;
         end
         atd_pkg::ST_CSQ: begin
            cmd.csq = 1'b1;
            sel_in = 2'd0;
            state_in = atd_pkg::ST_CROOT;
         end
         atd_pkg::ST_CROOT: begin
            cmd.root_step = 1'b1;
            if (stat.root_done) begin
               cmd.root_step = 1'b0;
               cmd.cord_init = 1'b1;
               state_in = atd_pkg::ST_CORD;
            end
         end
         atd_pkg::ST_CORD: begin
            cmd.cord_step = 1'b1;
            if (stat.cord_done) begin
               cmd.cord_step = 1'b0;
               state_in = atd_pkg::ST_DONE;
            end
         end
         atd_pkg::ST_DONE: begin
            cmd.cord_store = 1'b1;
            if (sel_ff == 2'd2) state_in = atd_pkg::ST_OUT;
            else begin
               sel_in = sel_ff + 2'd1;
               state_in = atd_pkg::ST_CROOT;
            end
         end
         atd_pkg::ST_OUT: begin
            if (rsp_ready) state_in = atd_pkg::ST_IDLE;
         end
         default: state_in = atd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= atd_pkg::ST_IDLE;
         sel_ff <= 2'd0;
         cnt_ff <= 2'd0;
         ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
         ok_ff <= ok_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

FILE: rtl/affine_transform_decompose.sv
`timescale 1ns / 1ps
// Columns 0 to 2 are accepted back to back.
// Column 3 starts the decomposition: per column the sum of squares, a root and
// three divisions; then the cosine square, a root and a CORDIC run for each angle.
// One matrix in flight; the result holds until taken; bottom-right zero answers next cycle.
// Synchronous active-high reset returns the controller to idle; basis is unset.
module affine_transform_decompose (
   input logic clock,
   input logic reset,
   atd_req_if.sink   req,
   atd_rsp_if.source rsp
);
   atd_pkg::cmd_type  cmd;
   atd_pkg::stat_type stat;
   logic ok;
   logic signed [31:0] tx, ty, tz;
   logic [30:0] sx, sy, sz;
   logic signed [18:0] ax, ay, az;

   atd_control u_ctl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .ok, .cmd, .stat
   );

   atd_datapath u_dp (
      .clock, .cmd, .stat,
      .in_col(req.column_index), .in_e0(req.elem0), .in_e1(req.elem1),
      .in_e2(req.elem2), .in_e3(req.elem3),
      .o_tx(tx), .o_ty(ty), .o_tz(tz), .o_sx(sx), .o_sy(sy), .o_sz(sz),
      .o_ax(ax), .o_ay(ay), .o_az(az)
   );

   // zero every field on failure
   assign rsp.trans_x = ok ? tx : '0;
   assign rsp.trans_y = ok ? ty : '0;
   assign rsp.trans_z = ok ? tz : '0;
   assign rsp.scale_x = ok ? sx : '0;
   assign rsp.scale_y = ok ? sy : '0;
   assign rsp.scale_z = ok ? sz : '0;
   assign rsp.angle_x = ok ? ax : '0;
   assign rsp.angle_y = ok ? ay : '0;
   assign rsp.angle_z = ok ? az : '0;
   assign rsp.decomposed_ok = ok;
endmodule

FILE: sim/tb_affine_transform_decompose.sv
`timescale 1ns / 1ps
module tb_affine_transform_decompose;
   localparam int     FracBits = atd_pkg::FracBits;
   localparam longint PiQ30   = 64'd3373259426;
   localparam int     NumRand = 1830;

   typedef struct {
      logic [1:0]         col;
      logic signed [31:0] e0, e1, e2, e3;
   } column_beat_type;

   typedef struct {
      logic signed [31:0] tx, ty, tz;
      logic [30:0]        sx, sy, sz;
      logic signed [18:0] ax, ay, az;
      logic               ok;
   } decomp_type;

   logic clock;
   logic reset;

   atd_req_if req ();
   atd_rsp_if rsp ();

   affine_transform_decompose dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   column_beat_type stim_q[$];
   bit              typed_q[$];
   decomp_type      typed_res_q[$];
   decomp_type      pending_decomp_q[$];
   longint          basis[9];
   int              errors;
   int              send_idle;
   int              recv_stall;

   // clock: 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // timeout guard
   initial begin
      #200_000_000;
      $display("FAIL affine_transform_decompose");
      $finish;
   end

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(input logic [65:0] n);
      logic [65:0] r;
      logic [65:0] t;
      r = 0;
      for (int b = 32; b >= 0; b--) begin
         t = r | (66'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic longint unsigned column_length(input int c);
      logic [65:0] s;
      s = 0;
      for (int i = 0; i < 3; i++)
         s = s + 66'(magnitude(basis[c*3+i])) * 66'(magnitude(basis[c*3+i]));
      return int_sqrt(s);
   endfunction

   // divide by the floored length, truncating toward zero
   function automatic longint unit_scale(input longint e, input longint unsigned len);
      longint unsigned rem;
      longint unsigned q;
      rem = magnitude(e);
      q = 0;
      if (len == 0) return 0;
      if (rem >= len) begin
         q = 1;
         rem = rem - len;
      end
      for (int i = 0; i < FracBits; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= len) begin
            rem = rem - len;
            q = q | 1;
         end
      end
      return (e < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint arctan_step(input int i);
      case (i)
         0: return 843314857;
         1: return 497837829;
         2: return 263043837;
         3: return 133525159;
         4: return 67021687;
         5: return 33543516;
         6: return 16775851;
         7: return 8388437;
         8: return 4194283;
         9: return 2097149;
         default: return longint'(1) << (30 - i);
      endcase
   endfunction

   function automatic longint cordic_atan2(input longint y, input longint x);
      longint xs, ys, z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      xs = x * (longint'(1) << (30 - FracBits));
      ys = y * (longint'(1) << (30 - FracBits));
      if (xs < 0) begin
         z = (ys >= 0) ? PiQ30 : -PiQ30;
         xs = -xs;
         ys = -ys;
      end
      for (int i = 0; i < 30; i++) begin
         dx = ys >>> i;
         dy = xs >>> i;
         if (ys > 0) begin
            xs = xs + dx; ys = ys - dy; z = z + arctan_step(i);
         end else if (ys < 0) begin
            xs = xs - dx; ys = ys + dy; z = z - arctan_step(i);
         end else begin
            break;
         end
      end
      return (z + (longint'(1) << (29 - FracBits))) >>> (30 - FracBits);
   endfunction

   // update the basis; on column 3 return the decomposition
   function automatic bit decompose(input column_beat_type b, output decomp_type d);
      longint          n[9];
      longint unsigned len[3];
      longint          s, one, ax, ay, az;
      d = '{default: '0};
      one = longint'(1) << FracBits;
      if (b.col != 2'd3) begin
         basis[b.col*3+0] = b.e0;
         basis[b.col*3+1] = b.e1;
         basis[b.col*3+2] = b.e2;
         return 1'b0;
      end
      if (b.e3 == 0) return 1'b1;
      for (int k = 0; k < 3; k++) begin
         len[k] = column_length(k);
         for (int i = 0; i < 3; i++) n[k*3+i] = unit_scale(basis[k*3+i], len[k]);
      end
      s = -n[2];
      ay = cordic_atan2(s, longint'(int_sqrt(66'(one * one - s * s))));
      if (s == one || s == -one) begin
         ax = cordic_atan2(-n[6], n[4]);
         az = 0;
      end else begin
         ax = cordic_atan2(n[5], n[8]);
         az = cordic_atan2(n[1], n[0]);
      end
      d.tx = b.e0;
      d.ty = b.e1;
      d.tz = b.e2;
      d.sx = (len[0] > 64'h7FFFFFFF) ? 31'h7FFFFFFF : len[0][30:0];
      d.sy = (len[1] > 64'h7FFFFFFF) ? 31'h7FFFFFFF : len[1][30:0];
      d.sz = (len[2] > 64'h7FFFFFFF) ? 31'h7FFFFFFF : len[2][30:0];
      d.ax = ax[18:0];
      d.ay = ay[18:0];
      d.az = az[18:0];
      d.ok = 1'b1;
      return 1'b1;
   endfunction

   task automatic add_beat(input logic [1:0] col, input logic signed [31:0] e0, e1, e2, e3,
                           input bit typed, input decomp_type res);
      stim_q.push_back('{col, e0, e1, e2, e3});
      typed_q.push_back(typed);
      typed_res_q.push_back(res);
   endtask

   task automatic add_matrix(input logic signed [31:0] m[16]);
      decomp_type none;
      none = '{default: '0};
      for (int c = 0; c < 4; c++)
         add_beat(c[1:0], m[c*4], m[c*4+1], m[c*4+2], m[c*4+3], 1'b0, none);
   endtask

   function automatic logic signed [31:0] rand_elem();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return $urandom_range(0, 262143) - 131072;
         2: return 0;
         3: return 32'sh7FFFFFFF;
         4: return 32'sh80000000;
         5: return $urandom_range(0, 1) ? 32'sd65536 : -32'sd65536;
         default: return $urandom_range(0, 33554431) - 16777216;
      endcase
   endfunction

   task automatic build_stimulus();
      decomp_type             res, none;
      logic signed [31:0]     m[16];
      int                     order[3];
      int                     tmp, j, n;
      none = '{default: '0};
      // identity with a translation: unit scale, no rotation
      res = '{tx: 32'sd65536, ty: -32'sd131072, tz: 32'sd7, sx: 31'd65536, sy: 31'd65536,
              sz: 31'd65536, ax: '0, ay: '0, az: '0, ok: 1'b1};
      add_beat(2'd0, 32'sd65536, 0, 0, 32'sh7FFFFFFF, 1'b0, none);
      add_beat(2'd1, 0, 32'sd65536, 0, 32'sh80000000, 1'b0, none);
      add_beat(2'd2, 0, 0, 32'sd65536, -1, 1'b0, none);
      add_beat(2'd3, 32'sd65536, -32'sd131072, 32'sd7, 32'sd65536, 1'b1, res);
      // bottom-right zero: everything cleared
      add_beat(2'd3, 32'sh7FFFFFFF, 32'sh80000000, -1, 0, 1'b1, none);
      // extremes: saturating scale, most negative translation
      add_beat(2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 1'b0, none);
      add_beat(2'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 1'b0, none);
      add_beat(2'd2, 32'sh80000000, 32'sh7FFFFFFF, -1, 0, 1'b0, none);
      add_beat(2'd3, 32'sh80000000, 32'sh7FFFFFFF, -1, 32'sh80000000, 1'b0, none);
      // zero-length columns
      add_beat(2'd0, 0, 0, 0, 0, 1'b0, none);
      add_beat(2'd1, 0, 0, 0, 0, 1'b0, none);
      add_beat(2'd2, 0, 0, 0, 0, 1'b0, none);
      add_beat(2'd3, 1, 2, 3, 1, 1'b0, none);
      // gimbal lock both ways, then negative x in atan2
      add_beat(2'd0, 0, 0, 32'sd65536, 0, 1'b0, none);
      add_beat(2'd1, 0, 32'sd65536, 0, 0, 1'b0, none);
      add_beat(2'd2, -32'sd65536, 0, 0, 0, 1'b0, none);
      add_beat(2'd3, 0, 0, 0, 1, 1'b0, none);
      add_beat(2'd0, 0, 0, -32'sd300000, 5, 1'b0, none);
      add_beat(2'd3, 0, 0, 0, 1, 1'b0, none);
      add_beat(2'd0, -32'sd65536, 0, 0, 0, 1'b0, none);
      add_beat(2'd0, -32'sd65536, 32'sd1000, 0, 0, 1'b0, none);
      add_beat(2'd2, 0, 32'sd20, -32'sd65536, 0, 1'b0, none);
      add_beat(2'd1, 32'sd3, -32'sd65536, 32'sd9, 0, 1'b0, none);
      add_beat(2'd3, 32'sd5, 32'sd6, 32'sd7, -1, 1'b0, none);

      // random: mostly whole matrices, some repeats and stray columns
      n = 0;
      while (n < NumRand) begin
         for (int i = 0; i < 16; i++) m[i] = rand_elem();
         if ($urandom_range(0, 9) == 0) begin
            m[0] = 0; m[1] = $urandom_range(0, 3); m[2] = rand_elem();
         end
         if ($urandom_range(0, 9) == 0) m[15] = 0;
         if ($urandom_range(0, 3) == 0) begin
            add_matrix(m);
            n = n + 4;
         end else begin
            order = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int i = 0; i < 3; i++)
               add_beat(order[i][1:0], m[order[i]*4], m[order[i]*4+1], m[order[i]*4+2],
                        m[order[i]*4+3], 1'b0, none);
            if ($urandom_range(0, 4) == 0) begin
               j = $urandom_range(0, 2);
               add_beat(j[1:0], rand_elem(), rand_elem(), rand_elem(), rand_elem(), 1'b0, none);
               n = n + 1;
            end
            add_beat(2'd3, m[12], m[13], m[14], m[15], 1'b0, none);
            n = n + 4;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // receiver: stall at random according to the phase
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_stall);
   end

   // check each result beat against the oldest expectation
   always @(posedge clock) begin
      decomp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_decomp_q.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
         end else begin
            e = pending_decomp_q.pop_front();
            check_field("trans_x", e.tx, rsp.trans_x);
            check_field("trans_y", e.ty, rsp.trans_y);
            check_field("trans_z", e.tz, rsp.trans_z);
            check_field("scale_x", 32'(e.sx), 32'(rsp.scale_x));
            check_field("scale_y", 32'(e.sy), 32'(rsp.scale_y));
            check_field("scale_z", 32'(e.sz), 32'(rsp.scale_z));
            check_field("angle_x", 32'(e.ax), 32'(rsp.angle_x));
            check_field("angle_y", 32'(e.ay), 32'(rsp.angle_y));
            check_field("angle_z", 32'(e.az), 32'(rsp.angle_z));
            check_field("decomposed_ok", 32'(e.ok), 32'(rsp.decomposed_ok));
         end
      end
   end

   // sender
   initial begin
      column_beat_type b;
      decomp_type      d;
      int              total, ndir;
      errors = 0;
      send_idle = 0;
      recv_stall = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.column_index = '0;
      req.elem0 = '0;
      req.elem1 = '0;
      req.elem2 = '0;
      req.elem3 = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < 9; i++) basis[i] = 0;
      build_stimulus();
      ndir = 24;
      total = stim_q.size();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int k = 0; k < total; k++) begin
         // phases: none, sender idle, receiver stall, both
         case ((k < ndir) ? 0 : ((k - ndir) * 4) / (total - ndir))
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 47; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 47; end
            default: begin send_idle = 34; recv_stall = 34; end
         endcase
         b = stim_q[k];
         while ($urandom_range(0, 99) < send_idle) begin
            req.valid <= 1'b0;
            @(negedge clock);
         end
         req.valid <= 1'b1;
         req.column_index <= b.col;
         req.elem0 <= b.e0;
         req.elem1 <= b.e1;
         req.elem2 <= b.e2;
         req.elem3 <= b.e3;
         do @(posedge clock); while (!req.ready);
         if (decompose(b, d)) begin
            if (typed_q[k]) d = typed_res_q[k];
            pending_decomp_q.push_back(d);
         end
         @(negedge clock);
      end
      req.valid <= 1'b0;
      while (pending_decomp_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0)
         $display("PASS affine_transform_decompose");
      else
         $display("FAIL affine_transform_decompose");
      $finish;
   end
endmodule

FILE: filelist.f
rtl/atd_pkg.sv
rtl/atd_if.sv
rtl/atd_datapath.sv
rtl/atd_control.sv
rtl/affine_transform_decompose.sv
sim/tb_affine_transform_decompose.sv
